// ----- src/qte_pkg.sv -----
// Shared constants and helpers for the quaternion to Euler angle core.
// No dependencies; used by qte_cordic, quaternion_to_euler_angles_core and the testbench.
`default_nettype none
package qte_pkg;

  // Default number of CORDIC iterations and length of the arctangent table
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_LEN         = 24;

  // Angle accumulator: degrees * 2^16
  localparam int ACC_W = 26;
  localparam logic signed [ACC_W-1:0] DEG90 = ACC_W'(90 * 65536);

  // Square root of a 57-bit radicand gives 29 result bits, one per stage
  localparam int SQ_STAGES = 29;
  localparam int SQ_W      = 58;

  // Output limits in sixteenths of a degree
  localparam int LIM_FULL = 2880;
  localparam int LIM_HALF = 1440;

  // round(atan(2^-i) * 180/pi * 65536)
  function automatic logic signed [ACC_W-1:0] atan_entry(input int i);
    logic signed [ACC_W-1:0] t;
    case (i)
      0:  t = ACC_W'(2949120);
      1:  t = ACC_W'(1740967);
      2:  t = ACC_W'(919879);
      3:  t = ACC_W'(466945);
      4:  t = ACC_W'(234379);
      5:  t = ACC_W'(117304);
      6:  t = ACC_W'(58666);
      7:  t = ACC_W'(29335);
      8:  t = ACC_W'(14668);
      9:  t = ACC_W'(7334);
      10: t = ACC_W'(3667);
      11: t = ACC_W'(1833);
      12: t = ACC_W'(917);
      13: t = ACC_W'(458);
      14: t = ACC_W'(229);
      15: t = ACC_W'(115);
      16: t = ACC_W'(57);
      17: t = ACC_W'(29);
      18: t = ACC_W'(14);
      19: t = ACC_W'(7);
      20: t = ACC_W'(4);
      21: t = ACC_W'(2);
      22: t = ACC_W'(1);
      default: t = '0;
    endcase
    return t;
  endfunction

  // Round degrees*2^16 to sixteenths (ties up) and clamp to +-lim
  function automatic logic signed [13:0] to_sixteenths(input logic signed [ACC_W-1:0] acc,
                                                       input int lim);
    logic signed [ACC_W-1:0] r;
    logic signed [ACC_W-1:0] l;
    r = (acc + ACC_W'(2048)) >>> 12;
    l = ACC_W'(lim);
    if (r > l) r = l;
    if (r < -l) r = -l;
    return 14'(r);
  endfunction

endpackage
`default_nettype wire

// ----- src/quaternion_to_euler_angles_core.sv -----
// Top level: quaternion (Q2.14) to ZYX roll, pitch, yaw in sixteenths of a degree.
// Depends on qte_pkg and qte_cordic.
//
// Accepts one quaternion per clock while the output is not stalled and returns one
// result per transaction, in order. The pitch path is the longest: two product/sum
// stages, a squaring stage, the radicand stage, a 29-stage bit-per-stage square
// root, then the quadrant fold and one stage per CORDIC iteration, then rounding.
// Roll and yaw run their CORDICs in parallel early and are delayed to line up. The
// whole pipeline advances together; when the output holds a result that is not
// taken, in_ready drops and nothing moves. pitch_clamped is set when |2(wy - zx)|
// exceeds 1.0; the argument is then clamped.
`default_nettype none
module quaternion_to_euler_angles_core #(
  parameter int CORDIC_STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_quat_w,
  input  logic signed [15:0] in_quat_x,
  input  logic signed [15:0] in_quat_y,
  input  logic signed [15:0] in_quat_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [12:0] out_roll_angle,
  output logic signed [11:0] out_pitch_angle,
  output logic signed [12:0] out_yaw_angle,
  output logic               out_pitch_clamped
);
  import qte_pkg::*;

  localparam int N      = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
  localparam int LAT    = SQ_STAGES + 6 + N;
  localparam int RY_DLY = SQ_STAGES + 1;
  localparam int CL_DLY = SQ_STAGES + 3 + N;
  localparam logic signed [33:0] ONE_Q28 = 34'sd268435456;
  localparam logic [SQ_W-1:0]    ONE_Q56 = SQ_W'(1) << 56;

  logic            en;
  logic [LAT:1]    vld_r;

  // Stage 1: products
  logic signed [31:0] wx_r, yz_r, xx_r, yy_r, wz_r, xy_r, zz_r, wy_r, zx_r;
  // Stage 2: numerators, denominators, clamped arcsine argument
  logic signed [33:0] rn_r, rd_r, yn_r, yd_r;
  logic signed [29:0] s2_r;
  logic               cl2_r;
  logic signed [33:0] rn_nxt, rd_nxt, yn_nxt, yd_nxt, s_full;
  // Stage 3 and 4: square and radicand
  logic signed [59:0] sq_full;
  logic [56:0]        sq_r;
  logic [SQ_W-1:0]    v_r;
  logic signed [29:0] sd_r [0:SQ_STAGES+1];
  // Square root stages
  logic [SQ_W-1:0]    sv_r [0:SQ_STAGES-1];
  logic [SQ_W-1:0]    sr_r [0:SQ_STAGES-1];
  logic signed [29:0] c_in;
  // CORDIC results
  logic signed [ACC_W-1:0] roll_acc, yaw_acc, pitch_acc;
  logic signed [13:0]      roll_rnd, yaw_rnd, pitch_rnd;
  logic signed [12:0]      roll_r, yaw_r;
  logic signed [12:0]      rd_dly_r [0:RY_DLY-1];
  logic signed [12:0]      yd_dly_r [0:RY_DLY-1];
  logic                    cl_dly_r [0:CL_DLY-1];
  // Output registers
  logic signed [12:0] out_roll_r, out_yaw_r;
  logic signed [11:0] out_pitch_r;
  logic               out_cl_r;

  // Global advance: move when the output slot is empty or being taken
  assign en       = !vld_r[LAT] || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-1:1], in_valid};
    end
  end

  // Stage 1: the nine 16x16 products
  always_ff @(posedge clk) begin
    if (en) begin
      wx_r <= in_quat_w * in_quat_x;
      yz_r <= in_quat_y * in_quat_z;
      xx_r <= in_quat_x * in_quat_x;
      yy_r <= in_quat_y * in_quat_y;
      wz_r <= in_quat_w * in_quat_z;
      xy_r <= in_quat_x * in_quat_y;
      zz_r <= in_quat_z * in_quat_z;
      wy_r <= in_quat_w * in_quat_y;
      zx_r <= in_quat_z * in_quat_x;
    end
  end

  // Stage 2: sums in units of 2^-28
  assign rn_nxt = (34'(wx_r) + 34'(yz_r)) <<< 1;
  assign rd_nxt = ONE_Q28 - ((34'(xx_r) + 34'(yy_r)) <<< 1);
  assign yn_nxt = (34'(wz_r) + 34'(xy_r)) <<< 1;
  assign yd_nxt = ONE_Q28 - ((34'(yy_r) + 34'(zz_r)) <<< 1);
  assign s_full = (34'(wy_r) - 34'(zx_r)) <<< 1;

  always_ff @(posedge clk) begin
    if (en) begin
      rn_r <= rn_nxt;
      rd_r <= rd_nxt;
      yn_r <= yn_nxt;
      yd_r <= yd_nxt;
      if (s_full > ONE_Q28) begin
        s2_r  <= 30'(ONE_Q28);
        cl2_r <= 1'b1;
      end else if (s_full < -ONE_Q28) begin
        s2_r  <= 30'(-ONE_Q28);
        cl2_r <= 1'b1;
      end else begin
        s2_r  <= 30'(s_full);
        cl2_r <= 1'b0;
      end
    end
  end

  // Stage 3: s squared; stage 4: radicand 2^56 - s^2
  assign sq_full = s2_r * s2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r <= 57'(sq_full);
      v_r  <= ONE_Q56 - SQ_W'(sq_r);
    end
  end

  // Arcsine argument rides alongside the square root
  always_ff @(posedge clk) begin
    if (en) begin
      sd_r[0] <= s2_r;
    end
  end

  for (genvar k = 1; k <= SQ_STAGES + 1; k++) begin : g_sdly
    always_ff @(posedge clk) begin
      if (en) begin
        sd_r[k] <= sd_r[k-1];
      end
    end
  end

  // Square root, one result bit per stage
  for (genvar j = 0; j < SQ_STAGES; j++) begin : g_sqrt
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQ_STAGES - 1 - j));
    logic [SQ_W-1:0] v_in, r_in, trial;
    if (j == 0) begin : g_first
      assign v_in = v_r;
      assign r_in = '0;
    end else begin : g_next
      assign v_in = sv_r[j-1];
      assign r_in = sr_r[j-1];
    end
    assign trial = r_in + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (v_in >= trial) begin
          sv_r[j] <= v_in - trial;
          sr_r[j] <= (r_in >> 1) + BIT;
        end else begin
          sv_r[j] <= v_in;
          sr_r[j] <= r_in >> 1;
        end
      end
    end
  end

  assign c_in = 30'(sr_r[SQ_STAGES-1]);

  // Arctangent units
  qte_cordic #(.STEPS(N), .IW(34)) u_roll (
    .clk(clk), .en(en), .y_in(rn_r), .x_in(rd_r), .angle(roll_acc)
  );

  qte_cordic #(.STEPS(N), .IW(34)) u_yaw (
    .clk(clk), .en(en), .y_in(yn_r), .x_in(yd_r), .angle(yaw_acc)
  );

  qte_cordic #(.STEPS(N), .IW(30)) u_pitch (
    .clk(clk), .en(en), .y_in(sd_r[SQ_STAGES+1]), .x_in(c_in), .angle(pitch_acc)
  );

  assign roll_rnd  = to_sixteenths(roll_acc, LIM_FULL);
  assign yaw_rnd   = to_sixteenths(yaw_acc, LIM_FULL);
  assign pitch_rnd = to_sixteenths(pitch_acc, LIM_HALF);

  // Roll and yaw rounding, then delay to meet pitch
  always_ff @(posedge clk) begin
    if (en) begin
      roll_r      <= 13'(roll_rnd);
      yaw_r       <= 13'(yaw_rnd);
      rd_dly_r[0] <= roll_r;
      yd_dly_r[0] <= yaw_r;
      cl_dly_r[0] <= cl2_r;
    end
  end

  for (genvar k = 1; k < RY_DLY; k++) begin : g_rydly
    always_ff @(posedge clk) begin
      if (en) begin
        rd_dly_r[k] <= rd_dly_r[k-1];
        yd_dly_r[k] <= yd_dly_r[k-1];
      end
    end
  end

  for (genvar k = 1; k < CL_DLY; k++) begin : g_cldly
    always_ff @(posedge clk) begin
      if (en) begin
        cl_dly_r[k] <= cl_dly_r[k-1];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (en) begin
      out_roll_r  <= rd_dly_r[RY_DLY-1];
      out_yaw_r   <= yd_dly_r[RY_DLY-1];
      out_pitch_r <= 12'(pitch_rnd);
      out_cl_r    <= cl_dly_r[CL_DLY-1];
    end
  end

  assign out_valid         = vld_r[LAT];
  assign out_roll_angle    = out_roll_r;
  assign out_pitch_angle   = out_pitch_r;
  assign out_yaw_angle     = out_yaw_r;
  assign out_pitch_clamped = out_cl_r;

endmodule
`default_nettype wire

// ----- src/qte_cordic.sv -----
// Pipelined vectoring CORDIC: atan2(y, x) in degrees * 2^16.
// Depends on qte_pkg (arctangent table, accumulator width).
`default_nettype none
module qte_cordic #(
  parameter int STEPS = qte_pkg::CORDIC_STEPS_DEF,
  parameter int IW    = 34
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [IW-1:0]              y_in,
  input  logic signed [IW-1:0]              x_in,
  output logic signed [qte_pkg::ACC_W-1:0]  angle
);
  import qte_pkg::*;

  localparam int N  = (STEPS > ATAN_LEN) ? ATAN_LEN : STEPS;
  localparam int XW = IW + 3;  // headroom for CORDIC gain and quadrant swap

  logic signed [XW-1:0]    x_r [0:N];
  logic signed [XW-1:0]    y_r [0:N];
  logic signed [ACC_W-1:0] a_r [0:N];
  logic                    z_r [0:N];
  logic signed [XW-1:0]    xe;
  logic signed [XW-1:0]    ye;

  assign xe = XW'(x_in);
  assign ye = XW'(y_in);

  // Quadrant fold: bring left half-plane vectors to the right
  always_ff @(posedge clk) begin
    if (en) begin
      z_r[0] <= (x_in == '0) && (y_in == '0);
      if (xe < 0) begin
        if (ye >= 0) begin
          x_r[0] <= ye;
          y_r[0] <= -xe;
          a_r[0] <= DEG90;
        end else begin
          x_r[0] <= -ye;
          y_r[0] <= xe;
          a_r[0] <= -DEG90;
        end
      end else begin
        x_r[0] <= xe;
        y_r[0] <= ye;
        a_r[0] <= '0;
      end
    end
  end

  // One micro-rotation per stage
  for (genvar i = 0; i < N; i++) begin : g_iter
    localparam logic signed [ACC_W-1:0] T = atan_entry(i);
    always_ff @(posedge clk) begin
      if (en) begin
        z_r[i+1] <= z_r[i];
        if (y_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          a_r[i+1] <= a_r[i] + T;
        end else begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          a_r[i+1] <= a_r[i] - T;
        end
      end
    end
  end

  // Zero vector reads as angle zero
  assign angle = z_r[N] ? '0 : a_r[N];

endmodule
`default_nettype wire

// ----- src/qte_checker.sv -----
// Port-level checks for quaternion_to_euler_angles_core, bound to the top level.
// No package dependency; sees the top-level ports only.
`default_nettype none
module qte_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [12:0] out_roll_angle,
  input logic signed [11:0] out_pitch_angle,
  input logic signed [12:0] out_yaw_angle,
  input logic               out_pitch_clamped
);

  // A stalled result holds still
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_roll_angle)
      && $stable(out_pitch_angle) && $stable(out_yaw_angle) && $stable(out_pitch_clamped))
    else $error("result changed while stalled");

  // Empty output slot never blocks the input
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // Angles stay in range
  a_roll_yaw_rng: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_roll_angle <= 13'sd2880 && out_roll_angle >= -13'sd2880
      && out_yaw_angle <= 13'sd2880 && out_yaw_angle >= -13'sd2880)
    else $error("roll or yaw out of range");

  a_pitch_rng: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pitch_angle <= 12'sd1440 && out_pitch_angle >= -12'sd1440)
    else $error("pitch out of range");

endmodule

bind quaternion_to_euler_angles_core qte_checker u_qte_checker (.*);
`default_nettype wire

// ----- tb/quaternion_to_euler_angles_core_tb.sv -----
// Self-checking testbench for the quaternion to ZYX Euler angle core.
// Depends on qte_pkg and quaternion_to_euler_angles_core.
`timescale 1ns / 100ps

module quaternion_to_euler_angles_core_tb;
  import qte_pkg::*;

  localparam int  STEPS    = (CORDIC_STEPS_DEF > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS_DEF;
  localparam longint ONE_Q = 64'sd1 <<< 28;
  localparam int  WD_LIMIT = 5000;
  localparam int  DRAIN    = 80;

  typedef struct {
    logic signed [15:0] w, x, y, z;
  } quat_t;

  typedef struct {
    logic signed [12:0] roll;
    logic signed [11:0] pitch;
    logic signed [12:0] yaw;
    logic               clamped;
  } euler_t;

  // degrees * 2^16 per micro-rotation
  localparam longint ATAN_DEG[24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] in_quat_w = '0, in_quat_x = '0, in_quat_y = '0, in_quat_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [12:0] out_roll_angle;
  logic signed [11:0] out_pitch_angle;
  logic signed [12:0] out_yaw_angle;
  logic out_pitch_clamped;

  quat_t  pending_quats[$];
  euler_t expected_angles[$];
  quat_t  next_quat;
  int send_idle_pct = 0, recv_idle_pct = 0;
  int n_queued = 0, n_accepted = 0, n_checked = 0, n_clamped = 0;
  int mismatches = 0, quiet_cycles = 0;

  quaternion_to_euler_angles_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_quat_w(in_quat_w), .in_quat_x(in_quat_x),
    .in_quat_y(in_quat_y), .in_quat_z(in_quat_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_roll_angle(out_roll_angle), .out_pitch_angle(out_pitch_angle),
    .out_yaw_angle(out_yaw_angle), .out_pitch_clamped(out_pitch_clamped)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // vectoring CORDIC, angle in degrees * 2^16
  function automatic longint vector_angle(input longint yv, input longint xv);
    longint acc, t, xs, ys;
    acc = 0;
    if (xv == 0 && yv == 0) return 0;
    if (xv < 0) begin
      if (yv >= 0) begin
        t = xv; xv = yv; yv = -t; acc = 90 * 65536;
      end else begin
        t = xv; xv = -yv; yv = t; acc = -90 * 65536;
      end
    end
    for (int i = 0; i < STEPS; i++) begin
      xs = xv >>> i;
      ys = yv >>> i;
      if (yv >= 0) begin
        xv = xv + ys; yv = yv - xs; acc += ATAN_DEG[i];
      end else begin
        xv = xv - ys; yv = yv + xs; acc -= ATAN_DEG[i];
      end
    end
    return acc;
  endfunction

  function automatic longint round_deg16(input longint acc, input longint lim);
    longint r;
    r = (acc + 2048) >>> 12;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic euler_t predict_angles(input quat_t q);
    longint w, x, y, z, rn, rd, yn, yd, s, c;
    euler_t e;
    w = q.w; x = q.x; y = q.y; z = q.z;
    rn = 2 * (w * x + y * z);
    rd = ONE_Q - 2 * (x * x + y * y);
    yn = 2 * (w * z + x * y);
    yd = ONE_Q - 2 * (y * y + z * z);
    s  = 2 * (w * y - z * x);
    e.clamped = 1'b0;
    if (s > ONE_Q) begin
      s = ONE_Q; e.clamped = 1'b1;
    end else if (s < -ONE_Q) begin
      s = -ONE_Q; e.clamped = 1'b1;
    end
    c = longint'(floor_sqrt(longint'(ONE_Q * ONE_Q) - s * s));
    e.roll  = 13'(round_deg16(vector_angle(rn, rd), LIM_FULL));
    e.pitch = 12'(round_deg16(vector_angle(s, c), LIM_HALF));
    e.yaw   = 13'(round_deg16(vector_angle(yn, yd), LIM_FULL));
    return e;
  endfunction

  task automatic queue_quat(input int w, input int x, input int y, input int z);
    quat_t q;
    q.w = 16'(w); q.x = 16'(x); q.y = 16'(y); q.z = 16'(z);
    pending_quats.push_back(q);
    n_queued++;
  endtask

  // random component: mostly within the unit range, sometimes full scale
  function automatic int rand_comp(input int mode);
    if (mode == 0) return $urandom_range(32767 + 32768) - 32768;
    if (mode == 1) return $urandom_range(2 * 16384) - 16384;
    return $urandom_range(2 * 11600) - 11600;
  endfunction

  task automatic queue_random(input int count);
    int mode;
    for (int i = 0; i < count; i++) begin
      mode = $urandom_range(3);
      if (mode == 3) mode = 1;
      queue_quat(rand_comp(mode), rand_comp(mode), rand_comp(mode), rand_comp(mode));
    end
  endtask

  // wait until every queued transaction is accepted and every result returned
  task automatic drain_all();
    while (n_accepted != n_queued || expected_angles.size() != 0) @(posedge clk);
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_quats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        next_quat = pending_quats.pop_front();
        in_valid  <= 1'b1;
        in_quat_w <= next_quat.w;
        in_quat_x <= next_quat.x;
        in_quat_y <= next_quat.y;
        in_quat_z <= next_quat.z;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result-side backpressure
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // input monitor: predict on each accepted transaction
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      expected_angles.push_back(predict_angles('{in_quat_w, in_quat_x, in_quat_y, in_quat_z}));
      n_accepted++;
    end
  end

  // output monitor: compare against oldest expectation
  always @(posedge clk) begin
    euler_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_angles.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result transaction, exp none got r=%0d p=%0d y=%0d c=%0d",
                   out_roll_angle, out_pitch_angle, out_yaw_angle, out_pitch_clamped);
      end else begin
        e = expected_angles.pop_front();
        n_checked++;
        if (e.clamped) n_clamped++;
        if (out_roll_angle !== e.roll || out_pitch_angle !== e.pitch ||
            out_yaw_angle !== e.yaw || out_pitch_clamped !== e.clamped) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: result %0d exp r=%0d p=%0d y=%0d c=%0d got r=%0d p=%0d y=%0d c=%0d",
                     n_checked, e.roll, e.pitch, e.yaw, e.clamped, out_roll_angle,
                     out_pitch_angle, out_yaw_angle, out_pitch_clamped);
        end
      end
    end
  end

  // watchdog on stalled traffic
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WD_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, identity, half turns, pitch at and past +-1
    queue_quat(0, 0, 0, 0);
    queue_quat(16384, 0, 0, 0);
    queue_quat(32767, 32767, 32767, 32767);
    queue_quat(-32768, -32768, -32768, -32768);
    queue_quat(32767, -32768, 32767, -32768);
    queue_quat(0, 16384, 0, 0);
    queue_quat(0, 0, 0, 16384);
    queue_quat(0, 0, 16384, 0);
    queue_quat(-16384, 0, 0, 0);
    queue_quat(8192, 0, 16384, 0);
    queue_quat(8192, 0, -16384, 0);
    queue_quat(16384, 0, 16384, 0);
    queue_quat(16384, 0, -16384, 0);
    queue_quat(11585, 11585, 0, 0);
    queue_quat(11585, 0, 11585, 0);
    queue_quat(11585, 0, 0, 11585);
    queue_quat(8192, 8192, 8192, 8192);
    queue_quat(0, -32768, 0, 0);
    queue_quat(0, 0, 0, -32768);
    queue_quat(0, 32767, 32767, 0);

    // no idling
    send_idle_pct = 0; recv_idle_pct = 0;
    queue_random(250);
    drain_all();
    // sender idles; the drain above is the full pause before it
    send_idle_pct = 55; recv_idle_pct = 0;
    queue_random(260);
    drain_all();
    send_idle_pct = 0; recv_idle_pct = 55;
    queue_random(260);
    drain_all();
    send_idle_pct = 32; recv_idle_pct = 32;
    queue_random(260);
    drain_all();
    repeat (DRAIN) @(posedge clk);

    $display("Checked %0d results (%0d with clamped pitch) over four traffic patterns.",
             n_checked, n_clamped);
    if (mismatches == 0 && expected_angles.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("Mismatches: %0d", mismatches);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/qte_pkg.sv
src/qte_cordic.sv
src/quaternion_to_euler_angles_core.sv
src/qte_checker.sv
tb/quaternion_to_euler_angles_core_tb.sv
